@@ hdl/alert_dedup_set_with_flush_macros.svh @@
// Assertion macros shared by the duplicate-suppression block.
`ifndef ALERT_DEDUP_SET_WITH_FLUSH_MACROS_SVH
`define ALERT_DEDUP_SET_WITH_FLUSH_MACROS_SVH

// Same-cycle implication, sampled on clk, disabled during rst
`define AD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, disabled during rst
`define AD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/ad_pkg.sv @@
// Shared types and constants for the duplicate-suppression block.
package ad_pkg;

  localparam int unsigned AddrW = 32;
  localparam int unsigned RuleW = 32;
  localparam int unsigned TimeW = 32;
  localparam int unsigned IntvW = 16;
  localparam logic [IntvW-1:0] IntvReset = 16'd10;

  // One stored (address, rule) pair
  typedef struct packed {
    logic [AddrW-1:0] addr;
    logic [RuleW-1:0] rule;
  } pair_t;

  // Item sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_LOOKUP
  } st_t;

endpackage

@@ hdl/alert_dedup_set_with_flush.sv @@
// Top level: duplicate-suppression table of (address, rule) pairs with flush.
//
//  channel | signals                          | direction
//  --------+----------------------------------+----------
//  in      | in_valid/in_ready + item fields  | input
//  out     | out_valid/out_ready + results    | output
//  cfg     | cfg_valid/cfg_ready + cfg_data   | input
//
// Each item: ST_IDLE accepts it and checks the window and flush, then
// ST_LOOKUP compares the key against every cell and shifts on insert.
// A result sits in the output register; the next item is taken meanwhile,
// and its lookup waits while that register is still full.
// Reset (rst, synchronous) empties the table via the fill count; no sweep.
`include "alert_dedup_set_with_flush_macros.svh"

module alert_dedup_set_with_flush #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [ad_pkg::TimeW-1:0] time_s,
  input  logic                     is_ipv4,
  input  logic                     is_pseudo,
  input  logic                     is_tcp,
  input  logic                     is_udp,
  input  logic [ad_pkg::AddrW-1:0] dest_addr,
  input  logic [ad_pkg::RuleW-1:0] rule_id,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     matched,
  output logic                     report_new,
  output logic                     overflow,
  output logic [ad_pkg::AddrW-1:0] report_addr,
  output logic [ad_pkg::RuleW-1:0] report_rule,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [ad_pkg::IntvW-1:0] cfg_data
);
  import ad_pkg::*;

  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);

  st_t state, state_next;

  logic              accept;
  logic              flush;
  logic              out_free;
  logic              finish;
  logic [CW-1:0]     fill;
  pair_t             key;
  logic              key_match;
  pair_t             chain [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] hits;
  logic              any_hit;
  logic              is_new;
  logic              has_room;
  logic              insert;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  // window and flush interval
  ad_window u_window (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .time_s    (time_s),
    .flush     (flush)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    finish     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (out_free) begin
          finish     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // key capture
  always_ff @(posedge clk) begin
    if (accept) begin
      key.addr  <= dest_addr;
      key.rule  <= rule_id;
      key_match <= is_ipv4 && !is_pseudo && (is_tcp || is_udp);
    end
  end

  // row of cells, new pairs enter at the head
  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    pair_t prev;
    if (i == 0) begin : g_head
      assign prev = key;
    end else begin : g_body
      assign prev = chain[i-1];
    end
    ad_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk      (clk),
      .shift_en (insert),
      .prev     (prev),
      .key      (key),
      .fill     (fill),
      .held     (chain[i]),
      .hit      (hits[i])
    );
  end

  // lookup decision
  assign any_hit  = |hits;
  assign is_new   = key_match && !any_hit;
  assign has_room = fill < CW'(TABLE_ENTRIES);
  assign insert   = finish && is_new && has_room;

  // fill count: cleared by reset or by flush at accept, bumped on insert
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (accept && flush) begin
      fill <= '0;
    end else if (insert) begin
      fill <= fill + CW'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      matched     <= key_match;
      report_new  <= is_new;
      overflow    <= is_new && !has_room;
      report_addr <= key_match ? key.addr : '0;
      report_rule <= key_match ? key.rule : '0;
    end
  end

  // checks
  `AD_ASSERT_NOW(a_fill_bound, 1'b1, fill <= CW'(TABLE_ENTRIES), "fill count beyond table size")
  `AD_ASSERT_NEXT(a_flush_empties, accept && flush, fill == '0, "flush did not empty table")
  `AD_ASSERT_NEXT(a_insert_bumps, insert, fill == $past(fill) + CW'(1), "insert lost count")
  `AD_ASSERT_NOW(a_ovf_new, out_valid && overflow, report_new && matched, "overflow without new")

endmodule

@@ hdl/ad_cell.sv @@
// One table cell: holds a pair, shifts it on insert, compares it with the key.
module ad_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned CW  = 7
) (
  input  logic          clk,
  input  logic          shift_en,
  input  ad_pkg::pair_t prev,
  input  ad_pkg::pair_t key,
  input  logic [CW-1:0] fill,
  output ad_pkg::pair_t held,
  output logic          hit
);
  import ad_pkg::*;

  // occupied cells are the lowest fill entries, newest at the head
  always_ff @(posedge clk) begin
    if (shift_en) begin
      held <= prev;
    end
  end

  assign hit = (fill > CW'(IDX)) && (held == key);

endmodule

@@ hdl/ad_window.sv @@
// Flush interval register and time-window tracking.
module ad_window (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  input  logic [ad_pkg::IntvW-1:0] cfg_data,
  input  logic                    accept,
  input  logic [ad_pkg::TimeW-1:0] time_s,
  output logic                    flush
);
  import ad_pkg::*;

  logic [IntvW-1:0] interval;
  logic             window_open;
  logic [TimeW-1:0] window_start;
  logic [TimeW-1:0] elapsed;

  // a closed window opens at this item, so elapsed is zero then
  assign elapsed = time_s - (window_open ? window_start : time_s);
  assign flush   = !elapsed[TimeW-1] && (elapsed > TimeW'(interval));

  always_ff @(posedge clk) begin
    if (rst) begin
      interval     <= IntvReset;
      window_open  <= 1'b0;
      window_start <= '0;
    end else begin
      if (cfg_valid) begin
        interval <= cfg_data;
      end
      if (accept) begin
        if (flush) begin
          window_open <= 1'b0;
        end else if (!window_open) begin
          window_open  <= 1'b1;
          window_start <= time_s;
        end
      end
    end
  end

endmodule

@@ tb/sv/tb_alert_dedup_set_with_flush.sv @@
// Self-checking testbench for the duplicate-suppression table with flush.
module tb_alert_dedup_set_with_flush;
  import ad_pkg::*;

  localparam int unsigned TableDepth = 64;
  localparam int unsigned PoolSize   = 96;
  localparam int unsigned HoldCycles = 300;

  // One packet match attempt as offered on the input channel
  typedef struct {
    logic [TimeW-1:0] time_s;
    logic             is_ipv4;
    logic             is_pseudo;
    logic             is_tcp;
    logic             is_udp;
    logic [AddrW-1:0] dest_addr;
    logic [RuleW-1:0] rule_id;
  } packet_t;

  // One verdict as seen on the output channel
  typedef struct {
    logic             matched;
    logic             report_new;
    logic             overflow;
    logic [AddrW-1:0] addr;
    logic [RuleW-1:0] rule;
  } verdict_t;

  // Dedup table shadow and queue of verdicts still owed by the block
  class dedup_tracker;
    logic [IntvW-1:0] interval;
    logic [AddrW-1:0] seen_addr[TableDepth];
    logic [RuleW-1:0] seen_rule[TableDepth];
    int unsigned      fill;
    bit               win_open;
    logic [TimeW-1:0] win_start;
    verdict_t         pending_verdicts[$];
    int unsigned      errors;

    function new();
      interval = IntvReset;
      fill     = 0;
      win_open = 0;
      win_start = '0;
      errors   = 0;
    endfunction

    // Work out the verdict for an accepted packet and update the table
    function void note_packet(packet_t p);
      logic [TimeW-1:0] elapsed;
      verdict_t v;
      bit hit;
      if (!win_open) begin
        win_open  = 1;
        win_start = p.time_s;
      end
      elapsed = p.time_s - win_start;
      // negative elapsed time (clock stepped back) never flushes
      if (!elapsed[TimeW-1] && elapsed > {16'd0, interval}) begin
        win_open = 0;
        fill     = 0;
      end
      v = '{default: '0};
      v.matched = p.is_ipv4 && !p.is_pseudo && (p.is_tcp || p.is_udp);
      if (v.matched) begin
        v.addr = p.dest_addr;
        v.rule = p.rule_id;
        hit = 0;
        for (int i = 0; i < fill; i++)
          if (seen_addr[i] == p.dest_addr && seen_rule[i] == p.rule_id) hit = 1;
        if (!hit) begin
          v.report_new = 1;
          if (fill < TableDepth) begin
            seen_addr[fill] = p.dest_addr;
            seen_rule[fill] = p.rule_id;
            fill++;
          end else begin
            v.overflow = 1;
          end
        end
      end
      pending_verdicts.push_back(v);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %h, actual %h", name, want, got);
        errors++;
      end
    endfunction

    // Compare an accepted verdict with the oldest one owed
    function void check_verdict(verdict_t got);
      verdict_t want;
      if (pending_verdicts.size() == 0) begin
        $error("verdict transaction with nothing expected");
        errors++;
        return;
      end
      want = pending_verdicts.pop_front();
      compare_field("matched", want.matched, got.matched);
      compare_field("report_new", want.report_new, got.report_new);
      compare_field("overflow", want.overflow, got.overflow);
      compare_field("report_addr", want.addr, got.addr);
      compare_field("report_rule", want.rule, got.rule);
    endfunction
  endclass

  logic             clk;
  logic             rst       = 1'b1;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  logic [TimeW-1:0] time_s    = '0;
  logic             is_ipv4   = 1'b0;
  logic             is_pseudo = 1'b0;
  logic             is_tcp    = 1'b0;
  logic             is_udp    = 1'b0;
  logic [AddrW-1:0] dest_addr = '0;
  logic [RuleW-1:0] rule_id   = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic             matched;
  logic             report_new;
  logic             overflow;
  logic [AddrW-1:0] report_addr;
  logic [RuleW-1:0] report_rule;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [IntvW-1:0] cfg_data  = '0;

  dedup_tracker     tracker = new();
  int unsigned      send_idle_pct = 0;
  int unsigned      recv_idle_pct = 0;
  logic             hold_rx       = 1'b0;
  bit               hold_go       = 0;
  logic [TimeW-1:0] wall_s        = 32'd1000;
  logic [AddrW-1:0] pool_addr[PoolSize];
  logic [RuleW-1:0] pool_rule[PoolSize];

  alert_dedup_set_with_flush #(
    .TABLE_ENTRIES(TableDepth)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .time_s     (time_s),
    .is_ipv4    (is_ipv4),
    .is_pseudo  (is_pseudo),
    .is_tcp     (is_tcp),
    .is_udp     (is_udp),
    .dest_addr  (dest_addr),
    .rule_id    (rule_id),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .matched    (matched),
    .report_new (report_new),
    .overflow   (overflow),
    .report_addr(report_addr),
    .report_rule(report_rule),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  initial begin
    #3000000;
    $display("[alert_dedup_set_with_flush] ERROR");
    $finish;
  end

  // Long receiver hold-off so the block backs up and stalls its input
  initial begin
    wait (hold_go);
    hold_rx <= 1'b1;
    repeat (HoldCycles) @(posedge clk);
    hold_rx <= 1'b0;
  end

  // Output side: check each verdict transaction, then choose next ready
  initial begin
    verdict_t got;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        got.matched    = matched;
        got.report_new = report_new;
        got.overflow   = overflow;
        got.addr       = report_addr;
        got.rule       = report_rule;
        tracker.check_verdict(got);
      end
      out_ready <= !hold_rx && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic packet_t make_pkt(logic [31:0] t, logic [3:0] flags,
                                       logic [31:0] a, logic [31:0] r);
    packet_t p;
    p.time_s    = t;
    p.is_ipv4   = flags[3];
    p.is_pseudo = flags[2];
    p.is_tcp    = flags[1];
    p.is_udp    = flags[0];
    p.dest_addr = a;
    p.rule_id   = r;
    return p;
  endfunction

  // Offer one packet, holding it until the block takes it
  task automatic send_packet(packet_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    time_s    <= p.time_s;
    is_ipv4   <= p.is_ipv4;
    is_pseudo <= p.is_pseudo;
    is_tcp    <= p.is_tcp;
    is_udp    <= p.is_udp;
    dest_addr <= p.dest_addr;
    rule_id   <= p.rule_id;
    do @(posedge clk); while (!in_ready);
    tracker.note_packet(p);
  endtask

  task automatic drain;
    while (tracker.pending_verdicts.size() != 0) @(posedge clk);
  endtask

  // Change the flush interval once the block has gone quiet
  task automatic write_interval(logic [IntvW-1:0] v);
    drain();
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tracker.interval = v;
  endtask

  // Mostly well-formed TCP/UDP packets drawn from a pair pool, with some noise
  task automatic run_random(int n, int unsigned max_step, int unsigned jump_pct);
    int unsigned r;
    int unsigned idx;
    logic [3:0]  flags;
    logic [31:0] a;
    logic [31:0] rl;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < jump_pct)
        wall_s += $urandom_range(0, 2 * tracker.interval + 2);
      else if (r < 2 * jump_pct)
        wall_s = $urandom;
      else if (r < 2 * jump_pct + 3)
        wall_s -= $urandom_range(1, 20);
      else
        wall_s += $urandom_range(0, max_step);
      if ($urandom_range(99) < 80)
        flags = {2'b10, ($urandom_range(0, 2) == 0) ? 2'b11 :
                        ($urandom_range(0, 1) ? 2'b10 : 2'b01)};
      else
        flags = 4'($urandom);
      if ($urandom_range(99) < 85) begin
        idx = $urandom_range(0, PoolSize - 1);
        a   = pool_addr[idx];
        rl  = pool_rule[idx];
      end else begin
        a  = $urandom;
        rl = $urandom;
      end
      send_packet(make_pkt(wall_s, flags, a, rl));
    end
    in_valid <= 1'b0;
  endtask

  // Main sequence
  initial begin
    for (int i = 0; i < PoolSize; i++) begin
      pool_addr[i] = $urandom;
      pool_rule[i] = $urandom;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at the reset interval of ten seconds
    send_idle_pct = 18;
    recv_idle_pct = 73;
    send_packet(make_pkt(32'd100, 4'b1010, 32'h0, 32'h0));
    send_packet(make_pkt(32'd100, 4'b1010, 32'h0, 32'h0));        // duplicate
    send_packet(make_pkt(32'd101, 4'b1001, 32'hFFFFFFFF, 32'hFFFFFFFF));
    for (int f = 0; f < 16; f++)                                   // every flag mix
      send_packet(make_pkt(32'd103, 4'(f), 32'(f), 32'h5));
    send_packet(make_pkt(32'd110, 4'b1010, 32'h0, 32'h0));        // at the limit
    send_packet(make_pkt(32'd111, 4'b1010, 32'h0, 32'h0));        // one past: flush
    send_packet(make_pkt(32'd0, 4'b1010, 32'h0, 32'h0));          // opens new window
    send_packet(make_pkt(32'hFFFFFFFF, 4'b1010, 32'h0, 32'h0));   // clock stepped back
    send_packet(make_pkt(32'd11, 4'b1011, 32'h0, 32'h0));         // flush
    send_packet(make_pkt(32'hFFFFFFFA, 4'b1001, 32'h12345678, 32'h9));
    send_packet(make_pkt(32'd3, 4'b1001, 32'h12345678, 32'h9));   // wrapped, no flush
    send_packet(make_pkt(32'd5, 4'b1001, 32'h12345678, 32'h9));   // wrapped, flush
    in_valid <= 1'b0;

    // Longest window: table fills and overflows
    write_interval(16'hFFFF);
    run_random(160, 2, 0);

    // Zero interval: any forward step flushes
    send_idle_pct = 73;
    recv_idle_pct = 18;
    write_interval(16'h0000);
    run_random(100, 1, 0);

    // Short random interval, no idling, long receiver hold-off at the start
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_interval(16'($urandom_range(1, 30)));
    hold_go = 1;
    run_random(190, 3, 5);

    drain();
    repeat (20) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending_verdicts.size() == 0)
      $display("[alert_dedup_set_with_flush] OK");
    else
      $display("[alert_dedup_set_with_flush] ERROR");
    $finish;
  end

endmodule
